>>> rtl/id_table_insert_find_update_delete_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key table
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ID_TABLE_INSERT_FIND_UPDATE_DELETE_DEFINES_SVH
`define ID_TABLE_INSERT_FIND_UPDATE_DELETE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IDT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define IDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/idt_pkg.sv
// ----------------------------------------------------------------------------
// idt_pkg
// Types and constants shared by the key table top level and its cells.
// ----------------------------------------------------------------------------
package idt_pkg;

   localparam int DEFAULT_ENTRIES = 16;

   localparam int KEY_W = 32;
   localparam int POS_W = 4;
   localparam int OP_W  = 3;
   localparam int ST_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND    = 3'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ    = 3'd4;

   localparam logic [ST_W-1:0] ST_DONE = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL = 2'd1;
   localparam logic [ST_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic             compare;
      logic [KEY_W-1:0] cmp_key;
      logic             commit;
      logic [KEY_W-1:0] wr_data;
      logic [POS_W-1:0] rd_index;
   } cell_ctl_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      logic [KEY_W-1:0] rd_data;
   } link_type;

endpackage

>>> rtl/idt_cell.sv
// ----------------------------------------------------------------------------
// idt_cell
// One key slot: compares against the broadcast key, then takes part in the
// lowest-match ripple and writes back when it is the first match.
// ----------------------------------------------------------------------------
module idt_cell import idt_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  link_type     link_prev,
   output link_type     link_next,
   output logic         selected
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_INDEX % 16);

   logic [KEY_W-1:0] slot_ff;
   logic [KEY_W-1:0] slot_in;
   logic             match_ff;
   logic             match_in;

   always_comb begin
      selected  = match_ff && !link_prev.found;
      link_next = link_prev;
      if (selected) begin
         link_next.found = 1'b1;
         link_next.pos   = MY_POS;
      end
      if (int'(ctl.rd_index) == CELL_INDEX) begin
         link_next.rd_data = slot_ff;
      end
      match_in = ctl.compare ? (slot_ff == ctl.cmp_key) : match_ff;
      slot_in  = (ctl.commit && selected) ? ctl.wr_data : slot_ff;
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

>>> rtl/id_table_insert_find_update_delete.sv
// ----------------------------------------------------------------------------
// id_table_insert_find_update_delete
// Small key table with first-free insert, lowest-match find, replace,
// delete and read by index.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one word per command carrying op, key, new_key
//   and slot_index. Response channel (rsp_*): one word per command carrying
//   status, position and slot_value.
//   The accept step compares every slot against the key at once and
//   registers the match flags; the execute state runs the lowest-match
//   ripple through the row of cells, writes back and registers the response.
//   No new command is taken while one is in the execute state.
//   A stalled receiver holds the response in the output register, and that
//   waiting word blocks the next request until the receiver takes it.
//   Reset clears every slot to zero (empty) and drops any pending response.
// ----------------------------------------------------------------------------
`include "id_table_insert_find_update_delete_defines.svh"

module id_table_insert_find_update_delete import idt_pkg::*; #(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_op,
   input  logic [KEY_W-1:0] req_key,
   input  logic [KEY_W-1:0] req_new_key,
   input  logic [POS_W-1:0] req_slot_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ST_W-1:0]  rsp_status,
   output logic [POS_W-1:0] rsp_position,
   output logic [KEY_W-1:0] rsp_slot_value
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [OP_W-1:0]  op_ff;
   logic [KEY_W-1:0] wdata_ff;
   logic [KEY_W-1:0] wdata_in;
   logic [POS_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [ST_W-1:0]  rsp_status_ff;
   logic [ST_W-1:0]  rsp_status_in;
   logic [POS_W-1:0] rsp_position_ff;
   logic [POS_W-1:0] rsp_position_in;
   logic [KEY_W-1:0] rsp_slot_value_ff;
   logic [KEY_W-1:0] rsp_slot_value_in;

   logic             req_fire;
   cell_ctl_type     ctl;
   link_type         links [ENTRIES+1];
   logic [ENTRIES-1:0] sel_vec;
   link_type         tail;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign tail      = links[ENTRIES];

   always_comb begin
      ctl.compare  = req_fire;
      ctl.cmp_key  = (req_op == OP_INSERT) ? '0 : req_key;
      ctl.commit   = (state_ff == S_EXEC) &&
                     (op_ff == OP_INSERT || op_ff == OP_REPLACE || op_ff == OP_DELETE);
      ctl.wr_data  = wdata_ff;
      ctl.rd_index = idx_ff;
   end

   assign links[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      idt_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .link_prev (links[i]),
         .link_next (links[i+1]),
         .selected  (sel_vec[i])
      );
   end

   always_comb begin
      unique case (req_op)
         OP_INSERT:  wdata_in = req_key;
         OP_REPLACE: wdata_in = req_new_key;
         default:    wdata_in = '0;
      endcase

      rsp_status_in     = ST_DONE;
      rsp_position_in   = '0;
      rsp_slot_value_in = '0;
      unique case (op_ff)
         OP_INSERT: begin
            rsp_status_in   = tail.found ? ST_DONE : ST_FULL;
            rsp_position_in = tail.pos;
         end
         OP_FIND, OP_REPLACE, OP_DELETE: begin
            rsp_status_in   = tail.found ? ST_DONE : ST_MISS;
            rsp_position_in = tail.pos;
         end
         OP_READ: begin
            rsp_position_in   = idx_ff;
            rsp_slot_value_in = tail.rd_data;
            rsp_status_in     = (int'(idx_ff) < ENTRIES) ? ST_DONE : ST_MISS;
         end
         default: begin
            rsp_status_in = ST_DONE;
         end
      endcase

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_op;
         wdata_ff <= wdata_in;
         idx_ff   <= req_slot_index;
      end
      if (state_ff == S_EXEC) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_position_ff   <= rsp_position_in;
         rsp_slot_value_ff <= rsp_slot_value_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_slot_value = rsp_slot_value_ff;

   `IDT_ASSERT_NEXT(a_accept_to_exec, req_fire, state_ff == S_EXEC && !req_ready, "no execute")
   `IDT_ASSERT_NEXT(a_exec_to_rsp, state_ff == S_EXEC, rsp_valid, "no response after execute")
   `IDT_ASSERT_NOW(a_one_select, state_ff == S_EXEC, $onehot0(sel_vec), "two slots selected")
   `IDT_ASSERT_NOW(a_fail_pos_zero, rsp_valid && rsp_status == ST_FULL, rsp_position == '0,
      "full with nonzero position")

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key table. A directed table runs first and
// covers the empty table, misses, an unused opcode, zero keys, duplicates
// and a full table. Random commands follow and come mostly from keys that
// the table holds. Responses are checked against typed rows or a shadow copy
// of the slots; the random phases use three sender and receiver idle profiles.
// ----------------------------------------------------------------------------
module testbench;
   import idt_pkg::*;

   localparam int SLOTS     = DEFAULT_ENTRIES;
   localparam int DIR_ROWS  = 26;
   localparam int PHASE_LEN = 234;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [POS_W-1:0] position;
      logic [KEY_W-1:0] slot_value;
   } rsp_word_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] new_key;
      logic [POS_W-1:0] slot_index;
      bit               typed;
      rsp_word_type     rsp;
   } dir_row_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [OP_W-1:0]  req_op         = OP_INSERT;
   logic [KEY_W-1:0] req_key        = '0;
   logic [KEY_W-1:0] req_new_key    = '0;
   logic [POS_W-1:0] req_slot_index = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic [ST_W-1:0]  rsp_status;
   logic [POS_W-1:0] rsp_position;
   logic [KEY_W-1:0] rsp_slot_value;

   logic [KEY_W-1:0] shadow_slots [SLOTS];
   rsp_word_type     pending_rsp [$];
   dir_row_type      dir_rows [DIR_ROWS];
   int               send_idle = 0;
   int               recv_idle = 0;
   bit               failed    = 1'b0;

   id_table_insert_find_update_delete #(.ENTRIES(SLOTS)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_new_key    (req_new_key),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_slot_value (rsp_slot_value)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rsp_word_type table_apply(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [KEY_W-1:0] new_key,
                                                input logic [POS_W-1:0] slot_index);
      rsp_word_type     r;
      logic [KEY_W-1:0] target;
      int               hit;
      r      = '{ST_DONE, '0, '0};
      hit    = -1;
      target = (op == OP_INSERT) ? '0 : key;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (shadow_slots[i] == target) hit = i;
      end
      case (op)
         OP_INSERT: begin
            if (hit < 0) begin
               r.status = ST_FULL;
            end else begin
               shadow_slots[hit] = key;
               r.position = hit[POS_W-1:0];
            end
         end
         OP_FIND, OP_REPLACE, OP_DELETE: begin
            if (hit < 0) begin
               r.status = ST_MISS;
            end else begin
               if (op == OP_REPLACE) shadow_slots[hit] = new_key;
               if (op == OP_DELETE) shadow_slots[hit] = '0;
               r.position = hit[POS_W-1:0];
            end
         end
         OP_READ: begin
            r.position = slot_index;
            if (int'(slot_index) < SLOTS) r.slot_value = shadow_slots[slot_index];
            else r.status = ST_MISS;
         end
         default: ;
      endcase
      return r;
   endfunction

   // hold the word until taken, then record what must come back
   task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [KEY_W-1:0] new_key,
                            input logic [POS_W-1:0] slot_index,
                            input bit typed, input rsp_word_type typed_rsp);
      rsp_word_type predicted;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_key        <= key;
      req_new_key    <= new_key;
      req_slot_index <= slot_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = table_apply(op, key, new_key, slot_index);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic drain_table;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word: status %0d position %0d value %h",
                     $time, rsp_status, rsp_position, rsp_slot_value);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp_position);
               failed = 1'b1;
            end
            if (rsp_slot_value !== want.slot_value) begin
               $display("%0t: slot_value expected %h actual %h",
                        $time, want.slot_value, rsp_slot_value);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] new_key;
      int               roll;
      int               ins_cut;
      for (int i = 0; i < SLOTS; i++) shadow_slots[i] = '0;
      dir_rows = '{
         '{OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd15, 1'b1, '{ST_DONE, 4'd15, 32'h0}},
         '{OP_FIND,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b1, '{ST_MISS, 4'd0, 32'h0}},
         '{OP_REPLACE,  32'h0000_0001, 32'hFFFF_FFFF, 4'd0,  1'b1, '{ST_MISS, 4'd0, 32'h0}},
         '{OP_DELETE,   32'h5A5A_5A5A, 32'h0000_0000, 4'd0,  1'b1, '{ST_MISS, 4'd0, 32'h0}},
         '{OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'hFFFF_FFFF, 32'h0000_0000, 4'd0,  1'b1, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_REPLACE,  32'hFFFF_FFFF, 32'h8000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_DELETE,   32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h8000_0000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_READ,     32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0001, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0002, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0004, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0008, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0010, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0020, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0040, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0080, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0100, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0200, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0400, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_0800, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_1000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h0000_2000, 32'h0000_0000, 4'd0,  1'b0, '{ST_DONE, 4'd0, 32'h0}},
         '{OP_INSERT,   32'h7FFF_FFFF, 32'h0000_0000, 4'd0,  1'b1, '{ST_FULL, 4'd0, 32'h0}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle = 20;
      recv_idle = 62;
      foreach (dir_rows[r]) begin
         send_word(dir_rows[r].op, dir_rows[r].key, dir_rows[r].new_key,
                   dir_rows[r].slot_index, dir_rows[r].typed, dir_rows[r].rsp);
      end
      drain_table();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 20 : (phase == 1) ? 62 : 0;
         recv_idle = (phase == 0) ? 62 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < PHASE_LEN; n++) begin
            // alternate fill-heavy and drain-heavy stretches
            ins_cut = ((n / 40) % 2 == 0) ? 45 : 20;
            roll = $urandom_range(99);
            if (roll < ins_cut) op = OP_INSERT;
            else if (roll < ins_cut + 15) op = OP_FIND;
            else if (roll < ins_cut + 27) op = OP_REPLACE;
            else if (roll < 82) op = OP_DELETE;
            else if (roll < 97) op = OP_READ;
            else op = OP_SPARE_LO + OP_W'($urandom_range(OP_SPARE_HI - OP_SPARE_LO));

            roll = $urandom_range(99);
            if (roll < 55) key = shadow_slots[$urandom_range(SLOTS - 1)];
            else if (roll < 75) key = $urandom_range(8, 1);
            else if (roll < 90) key = $urandom;
            else begin
               case ($urandom_range(3))
                  0: key = 32'h0000_0000;
                  1: key = 32'hFFFF_FFFF;
                  2: key = 32'h8000_0000;
                  default: key = 32'h7FFF_FFFF;
               endcase
            end

            roll = $urandom_range(99);
            if (roll < 50) new_key = $urandom;
            else if (roll < 80) new_key = $urandom_range(8, 1);
            else new_key = '0;

            send_word(op, key, new_key, POS_W'($urandom_range(SLOTS - 1)), 1'b0, '0);
         end
         drain_table();
      end

      repeat (8) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/idt_pkg.sv
rtl/idt_cell.sv
rtl/id_table_insert_find_update_delete.sv
tb/sv/testbench.sv
